>>> sv/olad_pkg.sv
// Shared types and codes for the ordered list block.
// Used by olad_ctrl, olad_dpath and ordered_list_append_delete.
`default_nettype none

package olad_pkg;

   localparam int COUNT_W = 5;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       append;
      logic       ptr_clear;
      logic       scan_run;
      logic       dump_load;
      logic       resp_load;
      logic [1:0] resp_status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       full;
      logic       scan_done;
      logic       found_now;
      logic       dump_last;
      logic       out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> sv/olad_dpath.sv
// Datapath: entry memory, length, scan and dump pointer, output word register.
// Depends on olad_pkg; driven by commands from olad_ctrl.
`default_nettype none

module olad_dpath #(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [31:0] req_value,
   input  wire logic               rsp_ready,
   input  wire olad_pkg::cmd_type  cmd,
   output olad_pkg::stat_type      stat,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_entry,
   output logic [olad_pkg::COUNT_W-1:0] rsp_count,
   output logic                    rsp_last
);
   import olad_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = $clog2(CAPACITY + 1);

   logic [31:0]         mem [CAPACITY];
   logic [31:0]         rdata_ff;

   logic [1:0]          op_ff, op_in;
   logic [31:0]         value_ff, value_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [LW-1:0]       ptr_ff, ptr_in;
   logic [LW-1:0]       idx_ff, idx_in;
   logic                dvalid_ff, dvalid_in;
   logic                found_ff, found_in;

   logic                out_valid_ff, out_valid_in;
   logic [1:0]          out_status_ff, out_status_in;
   logic [31:0]         out_entry_ff, out_entry_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;
   logic                out_last_ff, out_last_in;

   logic                match;
   logic                found_now;
   logic                scan_done;
   logic                dump_last;
   logic                shift_wr;
   logic [LW-1:0]       shift_idx;
   logic [LW-1:0]       ptr_next;

   assign match     = dvalid_ff && (rdata_ff == value_ff);
   assign found_now = found_ff || match;
   assign scan_done = dvalid_ff && (idx_ff == (len_ff - LW'(1)));
   assign ptr_next  = ptr_ff + LW'(1);
   assign dump_last = (ptr_next == len_ff);
   assign shift_wr  = cmd.scan_run && dvalid_ff && found_ff;
   assign shift_idx = idx_ff - LW'(1);

   assign stat.op        = op_ff;
   assign stat.empty     = (len_ff == '0);
   assign stat.full      = (len_ff >= LW'(CAPACITY));
   assign stat.scan_done = scan_done;
   assign stat.found_now = found_now;
   assign stat.dump_last = dump_last;
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         mem[len_ff[AW-1:0]] <= value_ff;
      end else if (shift_wr) begin
         mem[shift_idx[AW-1:0]] <= rdata_ff;
      end
      rdata_ff <= mem[ptr_ff[AW-1:0]];
   end

   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      len_in        = len_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      dvalid_in     = dvalid_ff;
      found_in      = found_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_entry_in  = out_entry_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;

      if (cmd.accept) begin
         op_in    = req_op;
         value_in = req_value;
      end
      if (cmd.append) begin
         len_in = len_ff + LW'(1);
      end
      if (cmd.ptr_clear) begin
         ptr_in    = '0;
         dvalid_in = 1'b0;
         found_in  = 1'b0;
      end
      if (cmd.scan_run) begin
         dvalid_in = (ptr_ff < len_ff);
         found_in  = found_now;
         if (ptr_ff < len_ff) begin
            ptr_in = ptr_next;
            idx_in = ptr_ff;
         end
         if (scan_done && found_now) begin
            len_in = len_ff - LW'(1);
         end
      end

      if (cmd.dump_load) begin
         ptr_in        = ptr_next;
         out_valid_in  = 1'b1;
         out_status_in = STAT_OK;
         out_entry_in  = rdata_ff;
         out_count_in  = COUNT_W'(len_ff);
         out_last_in   = dump_last;
      end else if (cmd.resp_load) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.resp_status;
         out_entry_in  = (op_ff == OP_DUMP) ? 32'd0 : value_ff;
         out_count_in  = COUNT_W'(len_ff);
         out_last_in   = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ptr_ff       <= '0;
         dvalid_ff    <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         dvalid_ff    <= dvalid_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      out_status_ff <= out_status_in;
      out_entry_ff  <= out_entry_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_entry  = out_entry_ff;
   assign rsp_count  = out_count_ff;
   assign rsp_last   = out_last_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(CAPACITY))
      else $error("length beyond capacity");
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (len_ff < LW'(CAPACITY)))
      else $error("append into full list");
   a_dump_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_load |-> !out_valid_ff)
      else $error("dump word overwrites pending word");
   a_resp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> (!out_valid_ff || rsp_ready))
      else $error("result overwrites pending word");
   a_delete_len: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_run && scan_done && found_now) |=> (len_ff == $past(len_ff) - LW'(1)))
      else $error("delete did not shrink list");
`endif

endmodule

`default_nettype wire

>>> sv/olad_ctrl.sv
// Controller state machine: sequences append, delete scan, dump and results.
// Depends on olad_pkg; commands olad_dpath.
`default_nettype none

module olad_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire olad_pkg::stat_type stat,
   output olad_pkg::cmd_type       cmd
);
   import olad_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_EXEC    = 6'b000010,
      S_SCAN    = 6'b000100,
      S_DUMP_RD = 6'b001000,
      S_DUMP_LD = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      cmd             = '0;
      cmd.resp_status = status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in  = S_RESP;
            status_in = STAT_OK;
            unique case (stat.op)
               OP_APPEND: begin
                  if (stat.full) begin
                     status_in = STAT_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (stat.empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     cmd.ptr_clear = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               OP_DUMP: begin
                  if (stat.empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     cmd.ptr_clear = 1'b1;
                     state_in      = S_DUMP_RD;
                  end
               end
               default: begin
                  status_in = STAT_OK;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               status_in = stat.found_now ? STAT_OK : STAT_NOT_FOUND;
               state_in  = S_RESP;
            end
         end
         S_DUMP_RD: begin
            if (stat.out_free) begin
               state_in = S_DUMP_LD;
            end
         end
         S_DUMP_LD: begin
            cmd.dump_load = 1'b1;
            state_in      = stat.dump_last ? S_IDLE : S_DUMP_RD;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.resp_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

`ifndef SYNTHESIS
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_EXEC))
      else $error("accept did not start execution");
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && stat.scan_done) |=> (state_ff == S_RESP))
      else $error("scan end not followed by result");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.dump_load && cmd.resp_load))
      else $error("two output loads in one cycle");
`endif

endmodule

`default_nettype wire

>>> sv/ordered_list_append_delete.sv
// Ordered list of signed 32-bit values with append, delete-first-match and dump.
// An append or an unused op code goes from acceptance through execute to its result word;
// a delete scans the list with one entry compared and shifted down per cycle
// through the single registered read port of the entry memory; a dump gives each
// word by a memory read, then an output load, while the consumer keeps up.
// A new request is taken once the last result is in the output register, even if
// that word has not yet been taken. Entries are undefined until appended.
// Depends on olad_pkg, olad_ctrl and olad_dpath.
`default_nettype none

module ordered_list_append_delete #(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_entry,
   output logic [olad_pkg::COUNT_W-1:0] rsp_count,
   output logic                    rsp_last
);
   import olad_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   olad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olad_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_value  (req_value),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_entry  (rsp_entry),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_last)
   );

endmodule

`default_nettype wire
